// ----- rtl/core/r5ram_pkg.sv -----
// ----------------------------------------------------------------------------
// r5ram_pkg
// Shared widths, constants, register indexes and types of the RAID 5 read
// address mapper.
// ----------------------------------------------------------------------------
package r5ram_pkg;

  localparam int OFFSET_BITS       = 48;
  localparam int MAX_REQUEST_BYTES = 131072;
  localparam int MAX_DRIVES        = 16;

  localparam int CHUNK_W   = 25;
  localparam int START_W   = 40;
  localparam int DRIVES_W  = 5;
  localparam int LEN_W     = 18;
  localparam int BUF_W     = 17;
  localparam int DISK_W    = 4;
  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = $clog2(OFFSET_BITS);

  localparam logic [CHUNK_W-1:0]  CHUNK_MIN    = CHUNK_W'(4096);
  localparam logic [CHUNK_W-1:0]  CHUNK_MAX    = CHUNK_W'(16777216);
  localparam logic [CHUNK_W-1:0]  CHUNK_RESET  = CHUNK_W'(512 * 1024);
  localparam logic [START_W-1:0]  START_RESET  = START_W'(2048 * 512);
  localparam logic [DRIVES_W-1:0] DRIVES_RESET = DRIVES_W'(3);
  localparam logic [DRIVES_W-1:0] DRIVES_MIN   = DRIVES_W'(3);
  localparam logic [DRIVES_W-1:0] DRIVES_MAX   = DRIVES_W'(MAX_DRIVES);
  localparam logic [LEN_W-1:0]    LEN_MAX      = LEN_W'(MAX_REQUEST_BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHUNK  = 2'd0,
    REG_START  = 2'd1,
    REG_DRIVES = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_DRAIN,
    ST_SUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] req_offset;
    logic [LEN_W-1:0]       req_length;
  } req_t;

  typedef struct packed {
    logic [DISK_W-1:0]      disk_index;
    logic [OFFSET_BITS-1:0] disk_offset;
    logic [LEN_W-1:0]       seg_length;
    logic [BUF_W-1:0]       buffer_offset;
    logic                   last;
  } result_t;

  // sequencer controls for the serial units
  typedef struct packed {
    logic clear;
    logic step;
  } ctl_t;

  // one quotient bit moving between the serial units
  typedef struct packed {
    logic valid;
    logic q;
  } qbit_t;

endpackage

// ----- rtl/core/r5ram_chunk_div.sv -----
// ----------------------------------------------------------------------------
// r5ram_chunk_div
// Bit-serial restoring divider: logical offset by chunk size, one quotient
// bit per cycle while step is high, most significant first.
// ----------------------------------------------------------------------------
module r5ram_chunk_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  r5ram_pkg::ctl_t                      ctl,
  input  logic [r5ram_pkg::OFFSET_BITS-1:0]    pos,
  input  logic [r5ram_pkg::CHUNK_W-1:0]        chunk,
  output r5ram_pkg::qbit_t                     qout,
  output logic [r5ram_pkg::CHUNK_W-1:0]        rem_out
);

  logic [r5ram_pkg::OFFSET_BITS-1:0] sh;
  logic [r5ram_pkg::CHUNK_W-1:0]     rem;
  logic [r5ram_pkg::CHUNK_W:0]       trial;
  logic [r5ram_pkg::CHUNK_W:0]       diff;
  logic                              ge;

  assign trial = {rem, sh[r5ram_pkg::OFFSET_BITS-1]};
  assign diff  = trial - {1'b0, chunk};
  assign ge    = (trial >= {1'b0, chunk});

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sh  <= pos;
      rem <= '0;
    end else if (ctl.step) begin
      sh  <= {sh[r5ram_pkg::OFFSET_BITS-2:0], 1'b0};
      rem <= ge ? diff[r5ram_pkg::CHUNK_W-1:0] : trial[r5ram_pkg::CHUNK_W-1:0];
    end
  end

  // quotient bit and its strobe, registered in the cycle after the step
  always_ff @(posedge clk) begin
    if (rst) begin
      qout.valid <= 1'b0;
    end else begin
      qout.valid <= ctl.step;
    end
    if (ctl.step) begin
      qout.q <= ge;
    end
  end

  assign rem_out = rem;

endmodule

// ----- rtl/core/r5ram_stripe.sv -----
// ----------------------------------------------------------------------------
// r5ram_stripe
// Consumes the chunk number bit-serially: divides it by the data disks per
// stripe, reduces the stripe number by the drive count and builds the
// stripe byte base by shift and add.
// ----------------------------------------------------------------------------
module r5ram_stripe (
  input  logic                                 clk,
  input  r5ram_pkg::ctl_t                      ctl,
  input  r5ram_pkg::qbit_t                     qin,
  input  logic [r5ram_pkg::DISK_W-1:0]         dm1,
  input  logic [r5ram_pkg::DRIVES_W-1:0]       drives,
  input  logic [r5ram_pkg::CHUNK_W-1:0]        chunk,
  output logic [r5ram_pkg::DISK_W-1:0]         sel,
  output logic [r5ram_pkg::DISK_W-1:0]         rot,
  output logic [r5ram_pkg::OFFSET_BITS-1:0]    acc
);

  logic [r5ram_pkg::DISK_W-1:0] r2;
  logic [r5ram_pkg::DISK_W-1:0] r3;
  logic [r5ram_pkg::DISK_W:0]   t2;
  logic [r5ram_pkg::DISK_W:0]   t3;
  logic [r5ram_pkg::DISK_W:0]   d2;
  logic [r5ram_pkg::DISK_W:0]   d3;
  logic                         q2;
  logic                         ge3;

  // stripe quotient bit
  assign t2 = {r2, qin.q};
  assign q2 = (t2 >= {1'b0, dm1});
  assign d2 = t2 - {1'b0, dm1};

  // stripe modulo drive count
  assign t3  = {r3, q2};
  assign ge3 = (t3 >= drives);
  assign d3  = t3 - drives;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      r2  <= '0;
      r3  <= '0;
      acc <= '0;
    end else if (qin.valid) begin
      r2  <= q2 ? d2[r5ram_pkg::DISK_W-1:0] : t2[r5ram_pkg::DISK_W-1:0];
      r3  <= ge3 ? d3[r5ram_pkg::DISK_W-1:0] : t3[r5ram_pkg::DISK_W-1:0];
      acc <= {acc[r5ram_pkg::OFFSET_BITS-2:0], 1'b0}
           + (q2 ? r5ram_pkg::OFFSET_BITS'(chunk) : '0);
    end
  end

  assign sel = r2;
  assign rot = r3;

endmodule

// ----- rtl/core/raid5_read_address_mapper.sv -----
// ----------------------------------------------------------------------------
// raid5_read_address_mapper
// Splits a logical read on a left-symmetric RAID 5 array into per-chunk
// segments with member disk, disk byte offset, length and buffer position.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the last segment has been issued. Each segment passes through a
// load state, a divide state in which the offset is divided by the chunk
// size one bit per cycle (the quotient bits feed, in the same pass, the
// division by the data disks per stripe, the reduction by the drive count
// and the shift-add stripe base), a drain state, a sum state and an issue
// state. A zero-length request produces no segments and busy does not
// rise. Every segment shows on result for exactly one cycle, marked by
// result_valid, in the cycle after it is issued; the receiver cannot stall,
// so it must take every segment as it appears. Lengths above 128 KiB are
// cut to 128 KiB; chunk size and drive count are clamped into their legal
// ranges when a request is taken. Configuration writes are taken at any time
// but belong between requests.
// ----------------------------------------------------------------------------
module raid5_read_address_mapper (
  input  logic                                 clk,
  input  logic                                 rst,
  // request transaction
  input  logic                                 start,
  output logic                                 busy,
  input  r5ram_pkg::req_t                      req,
  // segment transactions
  output logic                                 result_valid,
  output r5ram_pkg::result_t                   result,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [r5ram_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [r5ram_pkg::CFG_W-1:0]          cfg_data
);

  // configuration registers
  logic [r5ram_pkg::CHUNK_W-1:0]     chunk_bytes;
  logic [r5ram_pkg::START_W-1:0]     start_bytes;
  logic [r5ram_pkg::DRIVES_W-1:0]    drive_count;

  // sequencer
  r5ram_pkg::state_t                 state;
  r5ram_pkg::state_t                 state_next;
  logic [r5ram_pkg::CNT_W-1:0]       cnt;
  r5ram_pkg::ctl_t                   ctl;

  // per-request working registers
  logic [r5ram_pkg::CHUNK_W-1:0]     chunk_r;
  logic [r5ram_pkg::DRIVES_W-1:0]    drives_r;
  logic [r5ram_pkg::DISK_W-1:0]      dm1_r;
  logic [r5ram_pkg::OFFSET_BITS-1:0] pos;
  logic [r5ram_pkg::LEN_W-1:0]       remain;
  logic [r5ram_pkg::LEN_W-1:0]       done;

  // per-segment results
  logic [r5ram_pkg::OFFSET_BITS-1:0] base;
  logic [r5ram_pkg::LEN_W-1:0]       seg_len;
  logic [r5ram_pkg::DISK_W-1:0]      disk;

  // serial unit outputs
  r5ram_pkg::qbit_t                  qbit;
  logic [r5ram_pkg::CHUNK_W-1:0]     in_chunk;
  logic [r5ram_pkg::DISK_W-1:0]      sel;
  logic [r5ram_pkg::DISK_W-1:0]      rot;
  logic [r5ram_pkg::OFFSET_BITS-1:0] acc;

  // combinational helpers
  logic [r5ram_pkg::LEN_W-1:0]       len_clamped;
  logic [r5ram_pkg::CHUNK_W-1:0]     chunk_clamped;
  logic [r5ram_pkg::DRIVES_W-1:0]    drives_clamped;
  logic [r5ram_pkg::DRIVES_W-1:0]    dm1_full;
  logic [r5ram_pkg::CHUNK_W-1:0]     take;
  logic [r5ram_pkg::DRIVES_W:0]      disk_sum;
  logic [r5ram_pkg::DRIVES_W:0]      disk_wrap;
  logic [r5ram_pkg::LEN_W-1:0]       remain_after;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= r5ram_pkg::CHUNK_RESET;
      start_bytes <= r5ram_pkg::START_RESET;
      drive_count <= r5ram_pkg::DRIVES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        r5ram_pkg::REG_CHUNK:  chunk_bytes <= cfg_data[r5ram_pkg::CHUNK_W-1:0];
        r5ram_pkg::REG_START:  start_bytes <= cfg_data[r5ram_pkg::START_W-1:0];
        r5ram_pkg::REG_DRIVES: drive_count <= cfg_data[r5ram_pkg::DRIVES_W-1:0];
        default: ; // unknown index, ignored
      endcase
    end
  end

  // clamp length, chunk size and drive count at request entry
  always_comb begin
    len_clamped = (req.req_length > r5ram_pkg::LEN_MAX) ? r5ram_pkg::LEN_MAX
                                                        : req.req_length;
    if (chunk_bytes < r5ram_pkg::CHUNK_MIN) begin
      chunk_clamped = r5ram_pkg::CHUNK_MIN;
    end else if (chunk_bytes > r5ram_pkg::CHUNK_MAX) begin
      chunk_clamped = r5ram_pkg::CHUNK_MAX;
    end else begin
      chunk_clamped = chunk_bytes;
    end
    if (drive_count < r5ram_pkg::DRIVES_MIN) begin
      drives_clamped = r5ram_pkg::DRIVES_MIN;
    end else if (drive_count > r5ram_pkg::DRIVES_MAX) begin
      drives_clamped = r5ram_pkg::DRIVES_MAX;
    end else begin
      drives_clamped = drive_count;
    end
    dm1_full = drives_clamped - r5ram_pkg::DRIVES_W'(1);
  end

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      r5ram_pkg::ST_IDLE: begin
        if (start && (len_clamped != '0)) state_next = r5ram_pkg::ST_LOAD;
      end
      r5ram_pkg::ST_LOAD:   state_next = r5ram_pkg::ST_DIVIDE;
      r5ram_pkg::ST_DIVIDE: begin
        if (cnt == r5ram_pkg::CNT_W'(r5ram_pkg::OFFSET_BITS - 1)) begin
          state_next = r5ram_pkg::ST_DRAIN;
        end
      end
      r5ram_pkg::ST_DRAIN:  state_next = r5ram_pkg::ST_SUM;
      r5ram_pkg::ST_SUM:    state_next = r5ram_pkg::ST_EMIT;
      r5ram_pkg::ST_EMIT: begin
        state_next = (remain_after == '0) ? r5ram_pkg::ST_IDLE : r5ram_pkg::ST_LOAD;
      end
      default: state_next = r5ram_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != r5ram_pkg::ST_IDLE);
    ctl.clear = (state == r5ram_pkg::ST_LOAD);
    ctl.step  = (state == r5ram_pkg::ST_DIVIDE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= r5ram_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == r5ram_pkg::ST_EMIT);
    end
  end

  // bit counter of the divide pass
  always_ff @(posedge clk) begin
    if (state == r5ram_pkg::ST_LOAD) begin
      cnt <= '0;
    end else if (state == r5ram_pkg::ST_DIVIDE) begin
      cnt <= cnt + r5ram_pkg::CNT_W'(1);
    end
  end

  // ----------------------------------------------------------- serial units
  r5ram_chunk_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .pos     (pos),
    .chunk   (chunk_r),
    .qout    (qbit),
    .rem_out (in_chunk)
  );

  r5ram_stripe u_stripe (
    .clk    (clk),
    .ctl    (ctl),
    .qin    (qbit),
    .dm1    (dm1_r),
    .drives (drives_r),
    .chunk  (chunk_r),
    .sel    (sel),
    .rot    (rot),
    .acc    (acc)
  );

  // ------------------------------------------------------------- datapath
  always_comb begin
    // bytes left to the chunk end, never zero
    take         = chunk_r - in_chunk;
    // data slot plus drive count minus parity rotation, then one wrap
    disk_sum     = (r5ram_pkg::DRIVES_W + 1)'(sel) + (r5ram_pkg::DRIVES_W + 1)'(drives_r)
                 - (r5ram_pkg::DRIVES_W + 1)'(rot);
    disk_wrap    = disk_sum - (r5ram_pkg::DRIVES_W + 1)'(drives_r);
    remain_after = remain - seg_len;
  end

  always_ff @(posedge clk) begin
    case (state)
      r5ram_pkg::ST_IDLE: begin
        if (start) begin
          pos      <= req.req_offset;
          remain   <= len_clamped;
          done     <= '0;
          chunk_r  <= chunk_clamped;
          drives_r <= drives_clamped;
          dm1_r    <= dm1_full[r5ram_pkg::DISK_W-1:0];
        end
      end
      r5ram_pkg::ST_SUM: begin
        seg_len <= (take > r5ram_pkg::CHUNK_W'(remain)) ? remain
                                                        : take[r5ram_pkg::LEN_W-1:0];
        base    <= acc + r5ram_pkg::OFFSET_BITS'(in_chunk);
        disk    <= (disk_sum >= (r5ram_pkg::DRIVES_W + 1)'(drives_r))
                   ? disk_wrap[r5ram_pkg::DISK_W-1:0] : disk_sum[r5ram_pkg::DISK_W-1:0];
      end
      r5ram_pkg::ST_EMIT: begin
        // segment transaction goes out next cycle
        result.disk_index    <= disk;
        result.disk_offset   <= base + r5ram_pkg::OFFSET_BITS'(start_bytes);
        result.seg_length    <= seg_len;
        result.buffer_offset <= done[r5ram_pkg::BUF_W-1:0];
        result.last          <= (remain_after == '0);
        // advance to the next chunk, offset wraps at the offset width
        pos    <= pos + r5ram_pkg::OFFSET_BITS'(seg_len);
        remain <= remain_after;
        done   <= done + seg_len;
      end
      default: ;
    endcase
  end

endmodule
